// ===== design/cdq_pkg.sv =====
package cdq_pkg;

    localparam int DEPTH   = 1024;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int CMD_W   = 3;
    localparam int COUNT_W = 11;

    localparam logic signed [DATA_W-1:0] NO_DATA = -32'sd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_READ_FRONT = 3'd4,
        CMD_READ_BACK  = 3'd5,
        CMD_CLEAR      = 3'd6
    } cdq_cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_LOAD
    } cdq_state_t;

    // controller -> datapath commands
    typedef struct packed {
        logic exec;
        logic load;
    } cdq_ctl_t;

endpackage

// ===== design/cdq_if.sv =====
interface cdq_req_if;
    import cdq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] data_in;

    modport source (output valid, output cmd, output data_in, input ready);
    modport sink   (input valid, input cmd, input data_in, output ready);
endinterface

interface cdq_rsp_if;
    import cdq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] data_out;
    logic                     data_valid;
    logic                     push_dropped;
    logic [COUNT_W-1:0]       count;
    logic                     is_empty;

    modport source (output valid, output data_out, output data_valid, output push_dropped,
                    output count, output is_empty, input ready);
    modport sink   (input valid, input data_out, input data_valid, input push_dropped,
                    input count, input is_empty, output ready);
endinterface

// ===== design/cdq_ctrl.sv =====
module cdq_ctrl
    import cdq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output cdq_ctl_t ctl
);

    cdq_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        ctl.exec       = 1'b0;
        ctl.load       = 1'b0;
        req_ready      = 1'b0;
        out_valid_next = out_valid_reg && !rsp_ready;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid) begin
                    ctl.exec   = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                // wait for the output slot to free up
                if (!out_valid_reg || rsp_ready) begin
                    ctl.load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp_valid = out_valid_reg;

endmodule

// ===== design/cdq_dpath.sv =====
module cdq_dpath
    import cdq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cdq_ctl_t                 ctl,
    input  logic [CMD_W-1:0]         cmd,
    input  logic signed [DATA_W-1:0] data_in,
    output logic signed [DATA_W-1:0] data_out,
    output logic                     data_valid,
    output logic                     push_dropped,
    output logic [COUNT_W-1:0]       count,
    output logic                     is_empty
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
        return (i == LAST_IDX) ? '0 : i + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
        return (i == '0) ? LAST_IDX : i - IDX_W'(1);
    endfunction

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pend_data_reg, pend_data_next;
    logic             pend_drop_reg, pend_drop_next;

    logic signed [DATA_W-1:0] data_out_reg;
    logic                     data_valid_reg;
    logic                     push_dropped_reg;
    logic [COUNT_W-1:0]       count_out_reg;
    logic                     is_empty_reg;

    logic [IDX_W-1:0]         wr_addr, rd_addr;
    logic                     wr_en;
    logic                     empty, full;
    logic [CNT_W+COUNT_W-1:0] count_ext;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg >= CNT_W'(DEPTH));
    assign count_ext = {{COUNT_W{1'b0}}, count_reg};

    always_comb begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        wr_en          = 1'b0;
        wr_addr        = head_reg;
        rd_addr        = head_reg;
        pend_data_next = 1'b0;
        pend_drop_next = 1'b0;
        case (cdq_cmd_t'(cmd))
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (full) begin
                    pend_drop_next = 1'b1;
                end else begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    if (empty) begin
                        head_next = '0;
                        tail_next = '0;
                        wr_addr   = '0;
                    end else if (cdq_cmd_t'(cmd) == CMD_PUSH_FRONT) begin
                        head_next = idx_prev(head_reg);
                        wr_addr   = idx_prev(head_reg);
                    end else begin
                        tail_next = idx_next(tail_reg);
                        wr_addr   = idx_next(tail_reg);
                    end
                end
            end
            CMD_POP_FRONT:
            begin
                if (!empty) begin
                    rd_addr        = head_reg;
                    pend_data_next = 1'b1;
                    count_next     = count_reg - CNT_W'(1);
                    if (count_reg > CNT_W'(1)) begin
                        head_next = idx_next(head_reg);
                    end
                end
            end
            CMD_POP_BACK:
            begin
                if (!empty) begin
                    rd_addr        = tail_reg;
                    pend_data_next = 1'b1;
                    count_next     = count_reg - CNT_W'(1);
                    if (count_reg > CNT_W'(1)) begin
                        tail_next = idx_prev(tail_reg);
                    end
                end
            end
            CMD_READ_FRONT:
            begin
                rd_addr        = head_reg;
                pend_data_next = !empty;
            end
            CMD_READ_BACK:
            begin
                rd_addr        = tail_reg;
                pend_data_next = !empty;
            end
            CMD_CLEAR:
            begin
                head_next  = '0;
                tail_next  = '0;
                count_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            pend_data_reg <= 1'b0;
            pend_drop_reg <= 1'b0;
        end else if (ctl.exec) begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            pend_data_reg <= pend_data_next;
            pend_drop_reg <= pend_drop_next;
        end
    end

    always_ff @(posedge clk) begin
        if (ctl.exec && wr_en) begin
            mem[wr_addr] <= data_in;
        end
        if (ctl.exec) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // result register; pointers and count already reflect the command
    always_ff @(posedge clk) begin
        if (ctl.load) begin
            data_out_reg     <= pend_data_reg ? signed'(rd_data_reg) : NO_DATA;
            data_valid_reg   <= pend_data_reg;
            push_dropped_reg <= pend_drop_reg;
            count_out_reg    <= count_ext[COUNT_W-1:0];
            is_empty_reg     <= empty;
        end
    end

    assign data_out     = data_out_reg;
    assign data_valid   = data_valid_reg;
    assign push_dropped = push_dropped_reg;
    assign count        = count_out_reg;
    assign is_empty     = is_empty_reg;

endmodule

// ===== design/circular_deque.sv =====
// Double-ended queue of DEPTH signed 32-bit words in a ring buffer memory. Each request
// carries a command (push front/back, pop front/back, read front/back, clear) and a data
// word, and produces exactly one response with the popped or read word (-1 and data_valid
// low when there is none), a push-dropped flag for pushes to a full deque, and the count
// and empty flag after the command. A request first updates the pointers and writes or
// reads the ring memory, then, once the output slot is free, loads the registered read
// word into the response register. One request is in flight at a time; the next is
// taken once the response is loaded, while it may still wait for the sink. No clearing pass.
module circular_deque
    import cdq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    cdq_req_if.sink   cmd_ch,
    cdq_rsp_if.source rsp_ch
);

    cdq_ctl_t ctl;

    cdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (cmd_ch.valid),
        .req_ready (cmd_ch.ready),
        .rsp_valid (rsp_ch.valid),
        .rsp_ready (rsp_ch.ready),
        .ctl       (ctl)
    );

    cdq_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .cmd          (cmd_ch.cmd),
        .data_in      (cmd_ch.data_in),
        .data_out     (rsp_ch.data_out),
        .data_valid   (rsp_ch.data_valid),
        .push_dropped (rsp_ch.push_dropped),
        .count        (rsp_ch.count),
        .is_empty     (rsp_ch.is_empty)
    );

endmodule

// ===== design/cdq_checker.sv =====
module cdq_checker
    import cdq_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     req_valid,
    input logic                     req_ready,
    input logic                     rsp_valid,
    input logic                     rsp_ready,
    input logic signed [DATA_W-1:0] data_out,
    input logic                     data_valid,
    input logic                     push_dropped,
    input logic [COUNT_W-1:0]       count,
    input logic                     is_empty
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(data_out) && $stable(count))
        else $error("response changed while stalled");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second request taken before response loaded");

    a_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !data_valid |-> data_out == NO_DATA)
        else $error("data_out not -1 without data");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (data_valid || push_dropped) |-> !(data_valid && push_dropped) && !is_empty
            || data_valid && !push_dropped)
        else $error("inconsistent response flags");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && is_empty |-> count == '0 && !push_dropped)
        else $error("empty flag disagrees with count");

endmodule

bind circular_deque cdq_checker u_cdq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (cmd_ch.valid),
    .req_ready    (cmd_ch.ready),
    .rsp_valid    (rsp_ch.valid),
    .rsp_ready    (rsp_ch.ready),
    .data_out     (rsp_ch.data_out),
    .data_valid   (rsp_ch.data_valid),
    .push_dropped (rsp_ch.push_dropped),
    .count        (rsp_ch.count),
    .is_empty     (rsp_ch.is_empty)
);
